// File: rtl/pbrle_pkg.sv
package pbrle_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int VALUE_W     = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_W-1:0] WIDTH_RESET = VALUE_W'(8);
   localparam logic [VALUE_W-1:0] WIDTH_MAX   = VALUE_W'(MAX_WIDTH);

   typedef enum logic [1:0] {
      KIND_COLOR = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_EOR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_PIXEL,
      ST_FINAL,
      ST_EOR
   } state_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
      logic                 last;
   } record_type;

endpackage

// File: rtl/pbrle_queue.sv
module pbrle_queue (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] pop_data
);
   import pbrle_pkg::*;

   logic [7:0]        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/pbrle_back.sv
module pbrle_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pbrle_pkg::VALUE_W-1:0] width,
   input  logic                          q_empty,
   input  logic [7:0]                    q_data,
   output logic                          q_pop,
   output logic                          out_valid,
   output pbrle_pkg::record_type         out_rec,
   input  logic                          out_pop
);
   import pbrle_pkg::*;

   state_type          state_ff, state_in;
   logic               busy_ff, busy_in;
   logic [7:0]         byte_ff, byte_in;
   logic [2:0]         idx_ff, idx_in;
   logic               color_ff, color_in;
   logic [VALUE_W-1:0] run_ff, run_in;
   logic [VALUE_W-1:0] pos_ff, pos_in;
   record_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               bit_now;
   logic [VALUE_W-1:0] pos_next;
   logic [VALUE_W-1:0] run_plus;
   logic               row_start, color_change, row_end;
   logic               end_later, change_later;
   logic [7:0]         below_mask;
   logic               emit;
   record_type         rec;
   logic               out_free, advance, done;

   assign bit_now      = byte_ff[idx_ff];
   assign pos_next     = pos_ff + 1'b1;
   assign run_plus     = run_ff + 1'b1;
   assign row_start    = (pos_ff == '0);
   assign color_change = (bit_now != color_ff);
   assign row_end      = (pos_next >= width);
   assign below_mask   = (8'h01 << idx_ff) - 8'h01;
   assign change_later = |((byte_ff ^ {8{bit_now}}) & below_mask);
   assign end_later    = (({1'b0, pos_next} + {{(VALUE_W - 2){1'b0}}, idx_ff})
                          >= {1'b0, width});

   // record produced by the current step
   always_comb begin
      emit      = 1'b0;
      rec.kind  = KIND_RUN;
      rec.value = run_ff;
      rec.last  = 1'b0;
      unique case (state_ff)
         ST_PIXEL: begin
            if (row_start) begin
               emit      = 1'b1;
               rec.kind  = KIND_COLOR;
               rec.value = {{(VALUE_W - 1){1'b0}}, bit_now};
               rec.last  = !row_end && !change_later && !end_later;
            end else if (color_change) begin
               emit      = 1'b1;
               rec.value = run_ff;
               rec.last  = !row_end && !change_later && !end_later;
            end else if (row_end) begin
               emit      = 1'b1;
               rec.value = run_plus;
            end
         end
         ST_FINAL: begin
            emit      = 1'b1;
            rec.value = run_ff;
         end
         ST_EOR: begin
            emit      = 1'b1;
            rec.kind  = KIND_EOR;
            rec.value = '0;
            rec.last  = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || out_pop;
   assign advance  = busy_ff && (!emit || out_free);
   assign done     = advance && ((state_ff == ST_EOR) ||
                     (state_ff == ST_PIXEL && idx_ff == 3'd0 && !row_end));
   assign q_pop    = !q_empty && (!busy_ff || done);

   always_comb begin
      state_in = state_ff;
      if (q_pop) begin
         state_in = ST_PIXEL;
      end else if (advance) begin
         unique case (state_ff)
            ST_PIXEL: begin
               if (row_end) begin
                  state_in = (row_start || color_change) ? ST_FINAL : ST_EOR;
               end
            end
            ST_FINAL: state_in = ST_EOR;
            ST_EOR:   state_in = ST_PIXEL;
            default:  state_in = ST_PIXEL;
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      byte_in      = byte_ff;
      idx_in       = idx_ff;
      color_in     = color_ff;
      run_in       = run_ff;
      pos_in       = pos_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_pop;

      if (advance) begin
         if (emit) begin
            out_in       = rec;
            out_valid_in = 1'b1;
         end
         case (state_ff)
            ST_PIXEL: begin
               if (row_start || color_change) begin
                  color_in = bit_now;
                  run_in   = VALUE_W'(1);
               end else begin
                  run_in = run_plus;
               end
               pos_in = row_end ? '0 : pos_next;
               idx_in = idx_ff - 1'b1;
            end
            ST_EOR: begin
               run_in = '0;
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end

      if (done) begin
         busy_in = 1'b0;
      end
      if (q_pop) begin
         busy_in = 1'b1;
         byte_in = q_data;
         idx_in  = 3'd7;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      idx_ff  <= idx_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIXEL;
         busy_ff      <= 1'b0;
         color_ff     <= 1'b0;
         run_ff       <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         color_ff     <= color_in;
         run_ff       <= run_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rec   = out_ff;

endmodule

// File: rtl/packed_bilevel_row_rle_encoder.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_push / req_full     req_pixel_byte
// rsp_      out        rsp_pop / rsp_empty     rsp_record_kind, rsp_record_value,
//                                              rsp_last_of_item
// csr_      in         csr_write               csr_row_width
//
// The encoder takes one pixel per cycle unless a held rsp_ record stalls it. A row
// end adds a step for the end-of-row marker, and before it a step for the final run
// when the row's last pixel also emits a record of its own.
// A byte that ends a row early is finished there: its padding is skipped.
// A four-entry queue sits between input and encoder; rsp_ holds one record.
// Reset is synchronous and clears the queue, the row state and the width to 8.
// A held rsp_ transaction stalls the encoder; req_ stalls when the queue fills.
module packed_bilevel_row_rle_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [7:0]                    req_pixel_byte,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_record_kind,
   output logic [pbrle_pkg::VALUE_W-1:0] rsp_record_value,
   output logic                          rsp_last_of_item,
   input  logic                          csr_write,
   input  logic [pbrle_pkg::VALUE_W-1:0] csr_row_width
);
   import pbrle_pkg::*;

   logic [VALUE_W-1:0] width_ff, width_in;
   logic               q_empty, q_pop;
   logic [7:0]         q_data;
   logic               out_valid;
   record_type         out_rec;

   // clamp the row width once at write time
   always_comb begin
      width_in = width_ff;
      if (csr_write) begin
         if (csr_row_width == '0) begin
            width_in = VALUE_W'(1);
         end else if (csr_row_width > WIDTH_MAX) begin
            width_in = WIDTH_MAX;
         end else begin
            width_in = csr_row_width;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   pbrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_pixel_byte),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   pbrle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .width     (width_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_rec   (out_rec),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_record_kind  = out_rec.kind;
   assign rsp_record_value = out_rec.value;
   assign rsp_last_of_item = out_rec.last;

endmodule
